// ===== sv/xct_pkg.sv =====
// ----------------------------------------------------------------------------
// xct_pkg
// Shared types and codes for the streaming XML character tokenizer.
// ----------------------------------------------------------------------------
package xct_pkg;

   localparam logic [3:0] KIND_TEXT      = 4'd0;
   localparam logic [3:0] KIND_CDATA     = 4'd1;
   localparam logic [3:0] KIND_TAG       = 4'd2;
   localparam logic [3:0] KIND_KEY       = 4'd3;
   localparam logic [3:0] KIND_VAL       = 4'd4;
   localparam logic [3:0] KIND_KEY_END   = 4'd5;
   localparam logic [3:0] KIND_VAL_END   = 4'd6;
   localparam logic [3:0] KIND_CLOSENAME = 4'd7;
   localparam logic [3:0] KIND_OPEN      = 4'd8;
   localparam logic [3:0] KIND_CLOSE     = 4'd9;
   localparam logic [3:0] KIND_UNDER     = 4'd10;
   localparam logic [3:0] KIND_OVER      = 4'd11;
   localparam logic [3:0] KIND_FINISH    = 4'd12;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  out_char;
      logic [7:0]  depth;
      logic [31:0] line_no;
      logic        last;
   } event_type;

endpackage

// ===== sv/xml_char_tokenizer.sv =====
// ----------------------------------------------------------------------------
// xml_char_tokenizer
// Streaming XML tokenizer: one byte in, zero to three classified events out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per XML byte: tdata is the byte,
//   tuser[0] is the command (0 = character, 1 = end of file).
//   rsp channel carries one transaction per event; tlast marks the final
//   event produced by a request.
//   The tokenizer state, depth and line count update in the cycle a request
//   is accepted; its events are registered into a four-entry event queue
//   and appear on rsp from there, one event per cycle while rsp is ready.
//   Throughput is one request per cycle while each byte yields at most one
//   event and rsp keeps up; a byte that yields two or three events holds
//   rsp for each of them. The queue depth sets how far requests run ahead.
//   When rsp stalls, requests keep being taken until the queue cannot hold
//   another worst-case group of three events.
//   Reset clears the mode, depth, line count and queue; no events are lost
//   or repeated under any stall pattern.
// ----------------------------------------------------------------------------
module xml_char_tokenizer #(
   parameter int MAX_DEPTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [3:0] kind, [11:4] out_char, [19:12] depth,
                                    // [51:20] line_no, [55:52] zero
   output logic        rsp_tlast
);
   import xct_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

   localparam logic [4:0] M_TEXT      = 5'd0;
   localparam logic [4:0] M_LT        = 5'd1;
   localparam logic [4:0] M_TAGNAME   = 5'd2;
   localparam logic [4:0] M_ATTR      = 5'd3;
   localparam logic [4:0] M_KEY       = 5'd4;
   localparam logic [4:0] M_EQ        = 5'd5;
   localparam logic [4:0] M_VALUE     = 5'd6;
   localparam logic [4:0] M_SLASH     = 5'd7;
   localparam logic [4:0] M_CLOSE0    = 5'd8;
   localparam logic [4:0] M_CLOSENAME = 5'd9;
   localparam logic [4:0] M_PI        = 5'd10;
   localparam logic [4:0] M_PI_END    = 5'd11;
   localparam logic [4:0] M_BANG      = 5'd12;
   localparam logic [4:0] M_DASH      = 5'd13;
   localparam logic [4:0] M_CD_OPEN   = 5'd14;
   localparam logic [4:0] M_CDATA     = 5'd15;
   localparam logic [4:0] M_CD_RB1    = 5'd16;
   localparam logic [4:0] M_CD_RB2    = 5'd17;

   logic [4:0]         mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [31:0]        line_ff, line_in;

   event_type          queue_ff [4];
   logic [1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [2:0]         count_ff, count_in;

   event_type          ev [3];
   logic [1:0]         ev_n;

   logic               accept, pop;
   logic [7:0]         c;
   logic               ws;
   logic [DEPTH_W-1:0] d1;

   function automatic logic [7:0] dep8(input logic [DEPTH_W-1:0] d);
      logic [DEPTH_W+7:0] ext;
      ext = {8'd0, d};
      return ext[7:0];
   endfunction

   assign c   = req_tdata;
   assign ws  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   assign pop = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= 3'd1) || ((count_ff == 3'd2) && rsp_tready);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      line_in  = line_ff;
      d1       = depth_ff;
      ev_n     = 2'd0;
      for (int i = 0; i < 3; i++) begin
         ev[i] = '0;
      end
      if (req_tuser[0] == CMD_EOF) begin
         ev[0] = '{KIND_FINISH, 8'd0, dep8(depth_ff), line_ff, 1'b0};
         ev_n  = 2'd1;
      end else begin
         if (c == CH_LF) begin
            line_in = line_ff + 32'd1;
         end
         case (mode_ff)
            M_LT: begin
               if (c == CH_SLASH) mode_in = M_CLOSE0;
               else if (c == CH_QUEST) mode_in = M_PI;
               else if (c == CH_BANG) mode_in = M_BANG;
               else if (!ws) begin
                  mode_in = M_TAGNAME;
                  ev[0] = '{KIND_TAG, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_TAGNAME, M_ATTR: begin
               if (c == CH_GT) begin
                  mode_in = M_TEXT;
                  ev[0] = '{KIND_OPEN, 8'd0, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end else if (c == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (ws) begin
                  mode_in = M_ATTR;
               end else if (mode_ff == M_TAGNAME) begin
                  ev[0] = '{KIND_TAG, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end else begin
                  mode_in = M_KEY;
                  ev[0] = '{KIND_KEY, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_KEY: begin
               if (c == CH_EQ) begin
                  mode_in = M_EQ;
                  ev[0] = '{KIND_KEY_END, 8'd0, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end else if (!ws) begin
                  ev[0] = '{KIND_KEY, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_EQ: begin
               if (c == CH_QUOTE) mode_in = M_VALUE;
            end
            M_VALUE: begin
               if (c == CH_QUOTE) begin
                  mode_in = M_ATTR;
                  ev[0] = '{KIND_VAL_END, 8'd0, dep8(depth_ff), line_in, 1'b0};
               end else begin
                  ev[0] = '{KIND_VAL, c, dep8(depth_ff), line_in, 1'b0};
               end
               ev_n = 2'd1;
            end
            M_SLASH: begin
               if (c == CH_GT) begin
                  mode_in = M_TEXT;
                  ev[0] = '{KIND_OPEN, 8'd0, dep8(depth_ff), line_in, 1'b0};
                  ev[1] = '{KIND_CLOSE, 8'd0, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd2;
                  if (depth_ff == '0) begin
                     ev[2] = '{KIND_UNDER, 8'd0, dep8(depth_ff), line_in, 1'b0};
                     ev_n  = 2'd3;
                  end else begin
                     depth_in = depth_ff - DEPTH_W'(1);
                  end
               end else if (!ws) begin
                  mode_in = M_KEY;
                  ev[0] = '{KIND_KEY, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_CLOSE0: begin
               if (!ws) begin
                  mode_in = M_CLOSENAME;
                  ev[0] = '{KIND_CLOSENAME, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_CLOSENAME: begin
               if (c == CH_GT) begin
                  mode_in = M_TEXT;
                  if (depth_ff == '0) begin
                     ev[0] = '{KIND_UNDER, 8'd0, dep8(depth_ff), line_in, 1'b0};
                     ev[1] = '{KIND_CLOSE, 8'd0, dep8(depth_ff), line_in, 1'b0};
                     ev[2] = '{KIND_UNDER, 8'd0, dep8(depth_ff), line_in, 1'b0};
                     ev_n  = 2'd3;
                  end else begin
                     d1    = depth_ff - DEPTH_W'(1);
                     ev[0] = '{KIND_CLOSE, 8'd0, dep8(d1), line_in, 1'b0};
                     ev_n  = 2'd1;
                     if (d1 == '0) begin
                        ev[1]    = '{KIND_UNDER, 8'd0, dep8(d1), line_in, 1'b0};
                        ev_n     = 2'd2;
                        depth_in = d1;
                     end else begin
                        depth_in = d1 - DEPTH_W'(1);
                     end
                  end
               end else if (!ws) begin
                  ev[0] = '{KIND_CLOSENAME, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_PI: begin
               if ((c == CH_QUEST) || (c == CH_DASH)) mode_in = M_PI_END;
            end
            M_PI_END, M_CD_RB2: begin
               if (c == CH_GT) begin
                  mode_in = M_TEXT;
                  if (depth_ff == '0) begin
                     ev[0] = '{KIND_UNDER, 8'd0, dep8(depth_ff), line_in, 1'b0};
                     ev_n  = 2'd1;
                  end else begin
                     depth_in = depth_ff - DEPTH_W'(1);
                  end
               end else if (mode_ff == M_PI_END) begin
                  if ((c != CH_QUEST) && (c != CH_DASH)) mode_in = M_PI;
               end else if ((c != CH_SPACE) && (c != CH_TAB) && (c != CH_RBRACK)) begin
                  mode_in = M_CDATA;
                  ev[0] = '{KIND_CDATA, CH_RBRACK, dep8(depth_ff), line_in, 1'b0};
                  ev[1] = '{KIND_CDATA, CH_RBRACK, dep8(depth_ff), line_in, 1'b0};
                  ev[2] = '{KIND_CDATA, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd3;
               end
            end
            M_BANG: begin
               if (c == CH_DASH) mode_in = M_DASH;
               else if (c == CH_LBRACK) mode_in = M_CD_OPEN;
               else begin
                  mode_in = M_TAGNAME;
                  ev[0] = '{KIND_TAG, CH_BANG, dep8(depth_ff), line_in, 1'b0};
                  ev[1] = '{KIND_TAG, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd2;
               end
            end
            M_DASH: begin
               if (c == CH_DASH) mode_in = M_PI;
               else begin
                  mode_in = M_TAGNAME;
                  ev[0] = '{KIND_TAG, CH_BANG, dep8(depth_ff), line_in, 1'b0};
                  ev[1] = '{KIND_TAG, CH_DASH, dep8(depth_ff), line_in, 1'b0};
                  ev[2] = '{KIND_TAG, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd3;
               end
            end
            M_CD_OPEN: begin
               if (c == CH_LBRACK) mode_in = M_CDATA;
               else if ((c < CH_UPPER_A) || (c > CH_UPPER_Z)) mode_in = M_TAGNAME;
            end
            M_CDATA: begin
               if (c == CH_RBRACK) mode_in = M_CD_RB1;
               else begin
                  ev[0] = '{KIND_CDATA, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
            M_CD_RB1: begin
               if (c == CH_RBRACK) mode_in = M_CD_RB2;
               else if ((c != CH_SPACE) && (c != CH_TAB)) begin
                  mode_in = M_CDATA;
                  ev[0] = '{KIND_CDATA, CH_RBRACK, dep8(depth_ff), line_in, 1'b0};
                  ev[1] = '{KIND_CDATA, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd2;
               end
            end
            default: begin
               mode_in = M_TEXT;
               if (c == CH_LT) begin
                  mode_in = M_LT;
                  if (depth_ff >= DEPTH_MAX) begin
                     depth_in = DEPTH_MAX;
                     ev[0] = '{KIND_OVER, 8'd0, dep8(DEPTH_MAX), line_in, 1'b0};
                     ev_n  = 2'd1;
                  end else begin
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end else if (depth_ff != '0) begin
                  ev[0] = '{KIND_TEXT, c, dep8(depth_ff), line_in, 1'b0};
                  ev_n  = 2'd1;
               end
            end
         endcase
      end
      case (ev_n)
         2'd1:    ev[0].last = 1'b1;
         2'd2:    ev[1].last = 1'b1;
         2'd3:    ev[2].last = 1'b1;
         default: ev[0].last = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff - {2'd0, pop} + (accept ? {1'b0, ev_n} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_TEXT;
         depth_ff  <= '0;
         line_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         if (accept) begin
            mode_ff   <= mode_in;
            depth_ff  <= depth_in;
            line_ff   <= line_in;
            wr_ptr_ff <= wr_ptr_ff + ev_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < ev_n) begin
               queue_ff[wr_ptr_ff + 2'(i)] <= ev[i];
            end
         end
      end
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {4'd0, queue_ff[rd_ptr_ff].line_no, queue_ff[rd_ptr_ff].depth,
                        queue_ff[rd_ptr_ff].out_char, queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("event queue overfilled");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff - {2'd0, pop}) <= 3'd1)
      else $error("request taken without room for three events");

   a_eof_event: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] == CMD_EOF) |=> rsp_tvalid)
      else $error("end of file produced no event");

   a_eof_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] == CMD_EOF) |=> ($stable(mode_ff) && $stable(line_ff)))
      else $error("end of file changed tokenizer state");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= M_CD_RB2)
      else $error("tokenizer mode out of range");

endmodule
